// ===== hdl/bpsq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded prefix-sum query package
// Beat layouts, operation codes and fixed field widths shared by the block.
// ----------------------------------------------------------------------------
package bpsq_pkg;

   // fixed field widths
   localparam int DATA_BITS = 32;
   localparam int SUM_BITS  = 42;
   localparam int LEN_BITS  = 11;

   // operation codes of an input beat
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]           op;
      logic [DATA_BITS-1:0] item_value;
      logic [DATA_BITS-1:0] threshold;
   } req_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] prefix_total;
      logic [LEN_BITS-1:0] prefix_length;
      logic                overflowed;
   } rsp_type;

   // classified command: kind is one of clear, append, query
   typedef struct packed {
      logic [1:0]           kind;
      logic [DATA_BITS-1:0] operand;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hdl/bpsq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded prefix-sum query front end
// Accepts request beats, drops unused codes, selects the operand and holds
// the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module bpsq_front
   import bpsq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_take
);

   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  cnt_ff, cnt_in;
   logic                 accept;
   logic                 store;
   logic                 take;
   cmd_type              cmd_new;

   // classify the beat: pick operand by op, drop the unused code
   always_comb begin
      cmd_new.kind    = req_data.op;
      cmd_new.operand = (req_data.op == OP_APPEND) ? req_data.item_value
                                                   : req_data.threshold;
      store           = (req_data.op != OP_UNUSED);
   end

   assign full      = (cnt_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign take      = cmd_take && cmd_valid;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept && store) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if ((accept && store) && !take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!(accept && store) && take) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // write the queue slot
   always_ff @(posedge clock) begin
      if (accept && store) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/bpsq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded prefix-sum query back end
// Executes clear, append and query commands against the running-maximum and
// running-sum memories; a query binary-searches the maximum memory one probe
// per cycle, then reads the prefix sum, if any, into the result register.
// ----------------------------------------------------------------------------
module bpsq_back
   import bpsq_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_take,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   localparam int VW = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_TOTAL  = 2'd2;

   logic [VW-1:0]        max_mem [CAPACITY];
   logic [SUM_BITS-1:0]  sum_mem [CAPACITY];

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [VW-1:0]        rmax_ff, rmax_in;
   logic [SUM_BITS-1:0]  rsum_ff, rsum_in;
   logic                 drop_ff, drop_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        mid_ff, mid_in;
   logic [DATA_BITS-1:0] thr_ff, thr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [VW-1:0]        max_rd_ff;
   logic [SUM_BITS-1:0]  sum_rd_ff;

   logic                 wr_en;
   logic                 max_rd_en;
   logic [AW-1:0]        max_rd_addr;
   logic                 sum_rd_en;
   logic [AW-1:0]        sum_rd_addr;
   logic [VW-1:0]        value;
   logic [VW-1:0]        new_max;
   logic [SUM_BITS-1:0]  new_sum;
   logic                 probe_le;
   logic [CW-1:0]        nlo, nhi, nmid, nlast, start_mid;
   logic                 list_full;

   // append arithmetic
   always_comb begin
      value     = cmd.operand[VW-1:0];
      new_max   = ((count_ff == '0) || (value > rmax_ff)) ? value : rmax_ff;
      new_sum   = rsum_ff + SUM_BITS'(value);
      list_full = (count_ff == CW'(CAPACITY));
   end

   // one probe step of the binary search
   always_comb begin
      probe_le  = (DATA_BITS'(max_rd_ff) <= thr_ff);
      nlo       = probe_le ? (CW'(mid_ff) + 1'b1) : lo_ff;
      nhi       = probe_le ? hi_ff : CW'(mid_ff);
      nmid      = nlo + ((nhi - nlo) >> 1);
      nlast     = nlo - 1'b1;
      start_mid = count_ff >> 1;
   end

   // sequence commands
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rmax_in      = rmax_ff;
      rsum_in      = rsum_ff;
      drop_in      = drop_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cmd_take     = 1'b0;
      wr_en        = 1'b0;
      max_rd_en    = 1'b0;
      max_rd_addr  = mid_ff;
      sum_rd_en    = 1'b0;
      sum_rd_addr  = nlast[AW-1:0];

      // drop the result once popped
      if (rsp_valid_ff && pop) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  OP_CLEAR: begin
                     cmd_take = 1'b1;
                     count_in = '0;
                     rmax_in  = '0;
                     rsum_in  = '0;
                     drop_in  = 1'b0;
                  end
                  OP_APPEND: begin
                     cmd_take = 1'b1;
                     if (list_full) begin
                        drop_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        rmax_in  = new_max;
                        rsum_in  = new_sum;
                     end
                  end
                  OP_QUERY: begin
                     // hold the query until the result register is free
                     if (!rsp_valid_ff) begin
                        cmd_take = 1'b1;
                        thr_in   = cmd.operand;
                        if (count_ff == '0) begin
                           rsp_valid_in         = 1'b1;
                           rsp_in.prefix_total  = '0;
                           rsp_in.prefix_length = '0;
                           rsp_in.overflowed    = drop_ff;
                        end else begin
                           lo_in       = '0;
                           hi_in       = count_ff;
                           mid_in      = start_mid[AW-1:0];
                           max_rd_en   = 1'b1;
                           max_rd_addr = start_mid[AW-1:0];
                           state_in    = ST_SEARCH;
                        end
                     end
                  end
                  default: begin
                     cmd_take = 1'b1;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            lo_in = nlo;
            hi_in = nhi;
            if (nlo < nhi) begin
               mid_in      = nmid[AW-1:0];
               max_rd_en   = 1'b1;
               max_rd_addr = nmid[AW-1:0];
            end else if (nlo == '0) begin
               rsp_valid_in         = 1'b1;
               rsp_in.prefix_total  = '0;
               rsp_in.prefix_length = '0;
               rsp_in.overflowed    = drop_ff;
               state_in             = ST_IDLE;
            end else begin
               sum_rd_en = 1'b1;
               state_in  = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            rsp_valid_in         = 1'b1;
            rsp_in.prefix_total  = sum_rd_ff;
            rsp_in.prefix_length = LEN_BITS'(lo_ff);
            rsp_in.overflowed    = drop_ff;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rmax_ff      <= '0;
         rsum_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rmax_ff      <= rmax_in;
         rsum_ff      <= rsum_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // search registers and result payload
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      thr_ff <= thr_in;
      rsp_ff <= rsp_in;
   end

   // running-maximum and running-sum memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         max_mem[count_ff[AW-1:0]] <= new_max;
         sum_mem[count_ff[AW-1:0]] <= new_sum;
      end
      if (max_rd_en) begin
         max_rd_ff <= max_mem[max_rd_addr];
      end
      if (sum_rd_en) begin
         sum_rd_ff <= sum_mem[sum_rd_addr];
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   // search window stays nonempty and inside the list
   a_window : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> ((lo_ff < hi_ff) && (hi_ff <= count_ff)))
      else $error("search window out of range");

   // a query only runs while the result register is free
   a_busy_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("query running with a result pending");

   // list never grows past capacity
   a_count : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // the sum read always ends in a result
   a_total : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOTAL) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("sum read did not produce a result");
`endif

endmodule
`default_nettype wire

// ===== hdl/bounded_prefix_sum_query.sv =====
`default_nettype none
// A beat is registered in the front queue before the back end takes it. A
// query runs a start step, one probe per search step (up to 11 at 1024
// entries, one synchronous maximum-memory read each) and a sum read.
// Throughput: one clear/append per cycle while no query runs; no command is
// taken during a query, which starts only once the previous answer is popped.
// Reset (synchronous): empties list, drop flag and queue; memories keep contents.
// ----------------------------------------------------------------------------
// Bounded prefix-sum query
// Keeps a list of values with running maximum and running sum per position
// and answers threshold queries with the longest qualifying prefix sum.
// ----------------------------------------------------------------------------
module bounded_prefix_sum_query
   import bpsq_pkg::*;
#(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_take;

   // accept and classify beats
   bpsq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // execute commands and hold the result
   bpsq_back #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
